// ===== rtl/core/ile_pkg.sv =====
// shared types and constants for the indexed list engine
`timescale 1ns / 1ps

package ile_pkg;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [KIND_W-1:0] {
        K_APPEND    = 3'd0,
        K_INSERT    = 3'd1,
        K_OVERWRITE = 3'd2,
        K_REMOVE    = 3'd3,
        K_READ      = 3'd4,
        K_FIND      = 3'd5,
        K_CONTAINS  = 3'd6,
        K_CLEAR     = 3'd7
    } t_kind;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        C_HOLD   = 2'd0,
        C_WRITE  = 2'd1,
        C_INSERT = 2'd2,
        C_DELETE = 2'd3
    } t_cell_op;

    // broadcast to every cell
    typedef struct packed {
        t_cell_op               op;
        logic                   search;
        logic [VALUE_W-1:0]     value;
    } t_cell_cmd;

    // token that walks the cell row, one cell per cycle
    typedef struct packed {
        logic                   active;
        logic                   hit;
        logic [VALUE_W-1:0]     data;
    } t_probe;

endpackage

// ===== rtl/core/ile_if.sv =====
// request and response channel interfaces of the indexed list engine
`timescale 1ns / 1ps

interface ile_req_if import ile_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic [POS_W-1:0]           position;
    logic signed [VALUE_W-1:0]  operand_value;

    modport source (output valid, output kind, output position, output operand_value,
                    input ready);
    modport sink   (input valid, input kind, input position, input operand_value,
                    output ready);
endinterface

interface ile_rsp_if import ile_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  data_out;
    logic [COUNT_W-1:0]         element_count;

    modport source (output valid, output status, output data_out, output element_count,
                    input ready);
    modport sink   (input valid, input status, input data_out, input element_count,
                    output ready);
endinterface

// ===== rtl/core/ile_cell.sv =====
// one list cell: holds one element, shifts with its neighbors, forwards the probe
`timescale 1ns / 1ps

module ile_cell import ile_pkg::*; #(
    parameter int CW = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [CW-1:0]      i_idx,
    input  logic [CW-1:0]      i_ref,
    input  t_cell_cmd          i_cmd,
    input  logic [VALUE_W-1:0] i_left,
    input  logic [VALUE_W-1:0] i_right,
    input  t_probe             i_probe,
    output t_probe             o_probe,
    output logic [VALUE_W-1:0] o_elem
);

    logic [VALUE_W-1:0] r_elem;
    logic [VALUE_W-1:0] n_elem;
    t_probe             r_probe;
    t_probe             n_probe;
    logic               w_match;

    always_comb begin
        n_elem = r_elem;
        unique case (i_cmd.op)
            C_WRITE: begin
                if (i_idx == i_ref) n_elem = i_cmd.value;
            end
            C_INSERT: begin
                if (i_idx > i_ref) n_elem = i_left;
                else if (i_idx == i_ref) n_elem = i_cmd.value;
            end
            C_DELETE: begin
                if (i_idx >= i_ref) n_elem = i_right;
            end
            default: n_elem = r_elem;
        endcase
    end

    // search: value match below the fill level; index mode: this cell is the position
    assign w_match = i_cmd.search ? ((r_elem == i_cmd.value) && (i_idx < i_ref))
                                  : (i_idx == i_ref);

    always_comb begin
        n_probe = i_probe;
        if (i_probe.active && !i_probe.hit && w_match) begin
            n_probe.hit  = 1'b1;
            n_probe.data = i_cmd.search ? VALUE_W'(i_idx) : r_elem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_elem <= n_elem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

    assign o_probe = r_probe;
    assign o_elem  = r_elem;

endmodule

// ===== rtl/core/indexed_list_engine.sv =====
// append, insert, overwrite and clear need no probe: the result is valid the next cycle
// in-range read and remove, find index and contains send a probe down the cell row, one cell
// a cycle; their result is registered once the probe has left the last cell
// one operation is in flight at a time: probe-free kinds can be taken every cycle, a probe
// operation holds the input until its scan ends; a new one waits for a free result register
// synchronous active-low reset empties the list; element storage is not cleared
`timescale 1ns / 1ps

module indexed_list_engine import ile_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ile_req_if.sink   i_req,
    ile_rsp_if.source o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_ref, n_ref;
    t_kind                 r_kind, n_kind;
    logic [VALUE_W-1:0]    r_value, n_value;
    logic                  r_go, n_go;
    logic                  r_rsp_valid, n_rsp_valid;
    logic [STATUS_W-1:0]   r_rsp_status, n_rsp_status;
    logic [VALUE_W-1:0]    r_rsp_data, n_rsp_data;
    logic [COUNT_W-1:0]    r_rsp_count;

    t_cell_cmd             w_cmd;
    logic [CW-1:0]         w_cmd_ref;
    logic                  w_req_fire;
    logic [WW-1:0]         w_pos_x;
    logic [WW-1:0]         w_count_x;
    logic [CW-1:0]         w_pos_c;
    logic                  w_full;
    t_kind                 w_kind;

    logic [VALUE_W-1:0]    w_elem [CAPACITY];
    t_probe                w_probe [CAPACITY+1];

    assign i_req.ready = (r_state == S_IDLE) && (!r_rsp_valid || o_rsp.ready);
    assign w_req_fire  = i_req.valid && i_req.ready;
    assign w_kind      = t_kind'(i_req.kind);
    assign w_pos_x     = WW'(i_req.position);
    assign w_count_x   = WW'(r_count);
    assign w_pos_c     = CW'(i_req.position);
    assign w_full      = (r_count == CAP_C);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ref        = r_ref;
        n_kind       = r_kind;
        n_value      = r_value;
        n_go         = 1'b0;
        n_rsp_valid  = r_rsp_valid && !o_rsp.ready;
        n_rsp_status = r_rsp_status;
        n_rsp_data   = r_rsp_data;
        w_cmd.op     = C_HOLD;
        w_cmd.search = (r_kind == K_FIND) || (r_kind == K_CONTAINS);
        w_cmd.value  = r_value;
        w_cmd_ref    = r_ref;

        unique case (r_state)
            S_IDLE: begin
                w_cmd.value = i_req.operand_value;
                if (w_req_fire) begin
                    n_rsp_status = ST_DONE;
                    n_rsp_data   = '0;
                    n_kind       = w_kind;
                    n_value      = i_req.operand_value;
                    unique case (w_kind) inside
                        K_APPEND: begin
                            n_rsp_valid = 1'b1;
                            if (w_full) begin
                                n_rsp_status = ST_FULL;
                            end else begin
                                w_cmd.op  = C_WRITE;
                                w_cmd_ref = r_count;
                                n_count   = r_count + ONE_C;
                            end
                        end
                        K_INSERT: begin
                            n_rsp_valid = 1'b1;
                            if (w_pos_x > w_count_x) begin
                                n_rsp_status = ST_MISS;
                            end else if (w_full) begin
                                n_rsp_status = ST_FULL;
                            end else begin
                                w_cmd.op  = C_INSERT;
                                w_cmd_ref = w_pos_c;
                                n_count   = r_count + ONE_C;
                            end
                        end
                        K_OVERWRITE: begin
                            n_rsp_valid = 1'b1;
                            if (w_pos_x >= w_count_x) begin
                                n_rsp_status = ST_MISS;
                            end else begin
                                w_cmd.op  = C_WRITE;
                                w_cmd_ref = w_pos_c;
                            end
                        end
                        K_REMOVE, K_READ: begin
                            if (w_pos_x >= w_count_x) begin
                                n_rsp_valid  = 1'b1;
                                n_rsp_status = ST_MISS;
                            end else begin
                                n_ref   = w_pos_c;
                                n_go    = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        K_FIND, K_CONTAINS: begin
                            // search limit is the fill level
                            n_ref   = r_count;
                            n_go    = 1'b1;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_rsp_valid = 1'b1;
                            n_count     = '0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_probe[CAPACITY].active) begin
                    n_rsp_valid  = 1'b1;
                    n_state      = S_IDLE;
                    n_rsp_status = w_probe[CAPACITY].hit ? ST_DONE : ST_MISS;
                    n_rsp_data   = (w_probe[CAPACITY].hit && (r_kind != K_CONTAINS))
                                   ? w_probe[CAPACITY].data : '0;
                    if (r_kind == K_REMOVE) begin
                        w_cmd.op = C_DELETE;
                        n_count  = r_count - ONE_C;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_go        <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_go        <= n_go;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ref        <= n_ref;
        r_kind       <= n_kind;
        r_value      <= n_value;
        r_rsp_status <= n_rsp_status;
        r_rsp_data   <= n_rsp_data;
        if (n_rsp_valid && !(r_rsp_valid && !o_rsp.ready)) begin
            r_rsp_count <= COUNT_W'(n_count);
        end
    end

    assign w_probe[0] = '{active: r_go, hit: 1'b0, data: '0};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_W-1:0] w_left;
        logic [VALUE_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_cmd.value;
        end else begin : g_mid_l
            assign w_left = w_elem[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_elem[g];
        end else begin : g_mid_r
            assign w_right = w_elem[g+1];
        end

        ile_cell #(
            .CW (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (CW'(g)),
            .i_ref   (w_cmd_ref),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .i_probe (w_probe[g]),
            .o_probe (w_probe[g+1]),
            .o_elem  (w_elem[g])
        );
    end

    assign o_rsp.valid         = r_rsp_valid;
    assign o_rsp.status        = r_rsp_status;
    assign o_rsp.data_out      = r_rsp_data;
    assign o_rsp.element_count = r_rsp_count;

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("element count above capacity");

    a_scan_rsp_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !r_rsp_valid)
        else $error("result register busy during scan");

    a_probe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_probe[CAPACITY].active |-> (r_state == S_SCAN))
        else $error("probe left the row outside a scan");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req_fire && (w_kind == K_APPEND) && !w_full) |=>
            (r_count == $past(r_count) + ONE_C))
        else $error("append did not grow the list");

    a_index_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && w_probe[CAPACITY].active &&
         ((r_kind == K_READ) || (r_kind == K_REMOVE))) |-> w_probe[CAPACITY].hit)
        else $error("in-range read or remove found no cell");

endmodule
